[hdl/tgc_pkg.sv]
// Shared types, constants and axis scaling functions for the touch gesture classifier.
package tgc_pkg;

  localparam int RAW_W = 12;
  localparam int X_W   = 11;
  localparam int Y_W   = 10;
  localparam int THR_W = 8;
  localparam int GES_W = 3;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(20);

  localparam int SCREEN_WIDTH  = 800;
  localparam int RAW_X_SPAN    = 1024;
  localparam int SCREEN_HEIGHT = 480;
  localparam int RAW_Y_SPAN    = 600;

  // Scaling by a constant ratio is a multiply by a rounded-up reciprocal.
  // With 2^SHIFT above the largest raw value times the span, the truncated
  // product equals the truncating division for every raw value.
  localparam int X_SHIFT = RAW_W + $clog2(RAW_X_SPAN);
  localparam longint unsigned X_MULT =
    ((longint'(SCREEN_WIDTH) << X_SHIFT) + longint'(RAW_X_SPAN) - 1) / RAW_X_SPAN;
  localparam int X_MULT_W = $clog2(X_MULT + 1);
  localparam int X_PROD_W = RAW_W + X_MULT_W;

  localparam int Y_SHIFT = RAW_W + $clog2(RAW_Y_SPAN);
  localparam longint unsigned Y_MULT =
    ((longint'(SCREEN_HEIGHT) << Y_SHIFT) + longint'(RAW_Y_SPAN) - 1) / RAW_Y_SPAN;
  localparam int Y_MULT_W = $clog2(Y_MULT + 1);
  localparam int Y_PROD_W = RAW_W + Y_MULT_W;

  typedef enum logic [1:0] {
    OP_IGNORE = 2'd0,
    OP_RAW_X  = 2'd1,
    OP_RAW_Y  = 2'd2,
    OP_BUTTON = 2'd3
  } opcode_t;

  localparam logic [RAW_W-1:0] BTN_RELEASED = RAW_W'(0);
  localparam logic [RAW_W-1:0] BTN_PRESSED  = RAW_W'(1);

  typedef enum logic [GES_W-1:0] {
    G_TAP   = 3'd0,
    G_UP    = 3'd1,
    G_DOWN  = 3'd2,
    G_LEFT  = 3'd3,
    G_RIGHT = 3'd4
  } gesture_t;

  typedef struct packed {
    logic signed [X_W-1:0] x;
    logic signed [Y_W-1:0] y;
  } point_t;

  localparam point_t NO_POINT = '{x: '1, y: '1};

  function automatic logic signed [X_W-1:0] scale_x(input logic [RAW_W-1:0] raw);
    logic [X_PROD_W-1:0] prod;
    logic [X_PROD_W-1:0] quo;
    prod = {{X_MULT_W{1'b0}}, raw} * X_PROD_W'(X_MULT);
    quo  = prod >> X_SHIFT;
    if (quo > X_PROD_W'(SCREEN_WIDTH - 1)) begin
      scale_x = X_W'(SCREEN_WIDTH - 1);
    end else begin
      scale_x = quo[X_W-1:0];
    end
  endfunction

  function automatic logic signed [Y_W-1:0] scale_y(input logic [RAW_W-1:0] raw);
    logic [Y_PROD_W-1:0] prod;
    logic [Y_PROD_W-1:0] quo;
    prod = {{Y_MULT_W{1'b0}}, raw} * Y_PROD_W'(Y_MULT);
    quo  = prod >> Y_SHIFT;
    if (quo > Y_PROD_W'(SCREEN_HEIGHT - 1)) begin
      scale_y = Y_W'(SCREEN_HEIGHT - 1);
    end else begin
      scale_y = quo[Y_W-1:0];
    end
  endfunction

endpackage

[hdl/tgc_track.sv]
// Current and start point registers, updated by processed coordinate and button events.
module tgc_track (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  tgc_pkg::opcode_t              op,
  input  logic [tgc_pkg::RAW_W-1:0]     value,
  output tgc_pkg::point_t               cur,
  output tgc_pkg::point_t               start,
  output logic                          release_evt
);

  tgc_pkg::point_t cur_next;
  tgc_pkg::point_t start_next;

  always_comb begin
    cur_next    = cur;
    start_next  = start;
    release_evt = 1'b0;
    if (go) begin
      unique case (op)
        tgc_pkg::OP_RAW_X: cur_next.x = tgc_pkg::scale_x(value);
        tgc_pkg::OP_RAW_Y: cur_next.y = tgc_pkg::scale_y(value);
        tgc_pkg::OP_BUTTON: begin
          if (value == tgc_pkg::BTN_PRESSED) begin
            start_next = cur;
          end else if (value == tgc_pkg::BTN_RELEASED) begin
            // The result is taken from the old point; both points then clear.
            release_evt = 1'b1;
            cur_next    = tgc_pkg::NO_POINT;
            start_next  = tgc_pkg::NO_POINT;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur   <= tgc_pkg::NO_POINT;
      start <= tgc_pkg::NO_POINT;
    end else begin
      cur   <= cur_next;
      start <= start_next;
    end
  end

endmodule

[hdl/tgc_classify.sv]
// Gesture decision from the start and end points and the tap threshold.
module tgc_classify (
  input  tgc_pkg::point_t               cur,
  input  tgc_pkg::point_t               start,
  input  logic [tgc_pkg::THR_W-1:0]     threshold,
  output tgc_pkg::gesture_t             gesture
);

  logic signed [tgc_pkg::X_W:0]   dx;
  logic signed [tgc_pkg::Y_W:0]   dy;
  logic [tgc_pkg::X_W:0]          dx_mag;
  logic [tgc_pkg::Y_W:0]          dy_mag;
  logic [tgc_pkg::X_W-1:0]        ax;
  logic [tgc_pkg::Y_W-1:0]        ay;
  logic                           is_tap;

  always_comb begin
    dx = {cur.x[tgc_pkg::X_W-1], cur.x} - {start.x[tgc_pkg::X_W-1], start.x};
    dy = {cur.y[tgc_pkg::Y_W-1], cur.y} - {start.y[tgc_pkg::Y_W-1], start.y};
    dx_mag = dx[tgc_pkg::X_W] ? -dx : dx;
    dy_mag = dy[tgc_pkg::Y_W] ? -dy : dy;
    // Deltas never exceed the screen size, so one bit less holds the magnitude.
    ax = dx_mag[tgc_pkg::X_W-1:0];
    ay = dy_mag[tgc_pkg::Y_W-1:0];
    is_tap = (ax < tgc_pkg::X_W'(threshold)) && (ay < tgc_pkg::Y_W'(threshold));

    if (is_tap) begin
      gesture = tgc_pkg::G_TAP;
    end else if (ax > tgc_pkg::X_W'(ay)) begin
      gesture = (!dx[tgc_pkg::X_W] && dx != '0) ? tgc_pkg::G_RIGHT : tgc_pkg::G_LEFT;
    end else begin
      gesture = (!dy[tgc_pkg::Y_W] && dy != '0) ? tgc_pkg::G_DOWN : tgc_pkg::G_UP;
    end
  end

endmodule

[hdl/touch_gesture_classifier.sv]
// Touch gesture classifier: one item per cycle unless a result waits untaken. An accepted item
// sits in the input register; the processing step scales it, updates the point registers and,
// for a release, loads the result register, which then offers the result. Throughput is one
// item per cycle while results drain. Synchronous reset empties both registers, sets all
// points to -1 and the threshold to 20.
module touch_gesture_classifier (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    opcode,
  input  logic [tgc_pkg::RAW_W-1:0]     event_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tgc_pkg::GES_W-1:0]     gesture,
  output logic signed [tgc_pkg::X_W-1:0] end_x,
  output logic signed [tgc_pkg::Y_W-1:0] end_y,
  input  logic                          cfg_we,
  input  logic [tgc_pkg::THR_W-1:0]     cfg_data
);

  // Input register: holds one item until the processing step may run.
  logic                          in_vld;
  tgc_pkg::opcode_t              in_op;
  logic [tgc_pkg::RAW_W-1:0]     in_val;

  logic [tgc_pkg::THR_W-1:0]     tap_threshold;

  // The processing step runs whenever an item is held and the result register
  // is free or being emptied in this cycle.  Items that give no result take
  // the same path, which keeps the handshake simple and still one per cycle.
  logic                          go;
  logic                          release_evt;
  tgc_pkg::point_t               cur;
  tgc_pkg::point_t               start;
  tgc_pkg::gesture_t             ges;

  assign go       = in_vld && (!out_valid || out_ready);
  assign in_ready = !in_vld || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_ready) begin
      in_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_op  <= tgc_pkg::opcode_t'(opcode);
      in_val <= event_value;
    end
  end

  // The user must rewrite the threshold only while the block is idle; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_threshold <= tgc_pkg::THR_RESET;
    end else if (cfg_we) begin
      tap_threshold <= cfg_data;
    end
  end

  tgc_track u_track (
    .clk         (clk),
    .rst         (rst),
    .go          (go),
    .op          (in_op),
    .value       (in_val),
    .cur         (cur),
    .start       (start),
    .release_evt (release_evt)
  );

  tgc_classify u_classify (
    .cur       (cur),
    .start     (start),
    .threshold (tap_threshold),
    .gesture   (ges)
  );

  // Result register: a release loads it from the points as they stood before
  // the release cleared them.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go && release_evt) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && release_evt) begin
      gesture <= ges;
      end_x   <= cur.x;
      end_y   <= cur.y;
    end
  end

endmodule

[hdl/tgc_checker.sv]
// Port-level checks for the touch gesture classifier and their binding.
module tgc_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_ready,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [tgc_pkg::GES_W-1:0]     gesture,
  input  logic signed [tgc_pkg::X_W-1:0] end_x,
  input  logic signed [tgc_pkg::Y_W-1:0] end_y
);

  // Nothing is offered in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered right after reset");

  // The input side only stalls behind an unaccepted result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled with the result side free");

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(gesture) && $stable(end_x)
      && $stable(end_y)))
    else $error("stalled result changed");

  // End point lies on the screen or is the no-sample marker, and the gesture code is in range.
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (end_x >= -1 && end_x < tgc_pkg::SCREEN_WIDTH
      && end_y >= -1 && end_y < tgc_pkg::SCREEN_HEIGHT && gesture <= 3'd4))
    else $error("result outside screen or gesture code range");

endmodule

bind touch_gesture_classifier tgc_checker u_tgc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .gesture   (gesture),
  .end_x     (end_x),
  .end_y     (end_y)
);
